### design/crcfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC16 frame checker package
// Shared types, status codes, register indexes and the byte-wise CRC update.
// ----------------------------------------------------------------------------
package crcfc_pkg;

  localparam int POS_W         = 11;
  localparam int COUNT_W       = POS_W + 1;
  localparam int MAX_LEN_W     = 10;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 10;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [POS_W-1:0]     POS_MAX       = '1;
  localparam logic [15:0]          CRC_INIT      = 16'hFFFF;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 10'd260;
  localparam logic [POS_W-1:0]     POS_HEAD      = 11'd0;
  localparam logic [POS_W-1:0]     POS_CMD       = 11'd1;
  localparam logic [POS_W-1:0]     POS_LEN       = 11'd2;
  localparam logic [POS_W-1:0]     POS_PAYLOAD   = 11'd3;
  localparam logic [8:0]           FRAME_EXTRA   = 9'd5;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_BAD_HEAD  = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_BAD_CRC   = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_HEAD  = 2'd0,
    REG_BOTH_HEAD = 2'd1,
    REG_MAX_BURST = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]       rx_byte;
    logic             burst_end;
    logic [POS_W-1:0] pos;
  } entry_t;

  typedef struct packed {
    logic [7:0]           own_head;
    logic [7:0]           both_head;
    logic [MAX_LEN_W-1:0] max_burst;
  } cfg_t;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = {crc[7:0], crc[15:8]};
    c[7:0] = c[7:0] ^ b;
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage
`default_nettype wire

### design/crcfc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC16 frame checker channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
interface crcfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       burst_end;
  modport source (output valid, rx_byte, burst_end, input ready);
  modport sink (input valid, rx_byte, burst_end, output ready);
endinterface

interface crcfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       frame_done;
  logic [2:0] frame_status;
  logic [7:0] command_code;
  logic [7:0] payload_len;
  modport source (output valid, payload_byte, payload_valid, frame_done, frame_status,
                  command_code, payload_len, input ready);
  modport sink (input valid, payload_byte, payload_valid, frame_done, frame_status,
                command_code, payload_len, output ready);
endinterface

interface crcfc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [crcfc_pkg::CFG_IDX_W-1:0]     index;
  logic [crcfc_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/crcfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC16 frame checker front end
// Accepts bytes and tags each with its saturating position in the burst.
// ----------------------------------------------------------------------------
module crcfc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  crcfc_in_if.sink               in_ch,
  input  wire logic              q_full,
  output logic                   push_valid,
  output crcfc_pkg::entry_t      push_entry
);
  import crcfc_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             xfer;

  assign in_ch.ready = !q_full;
  assign xfer        = in_ch.valid && !q_full;
  assign push_valid  = xfer;
  assign push_entry  = '{rx_byte: in_ch.rx_byte, burst_end: in_ch.burst_end, pos: pos_r};

  always_comb begin
    pos_nxt = pos_r;
    if (xfer) begin
      if (in_ch.burst_end) begin
        pos_nxt = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

### design/crcfc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC16 frame checker queue
// Short first-in first-out queue of tagged bytes between front and back end.
// ----------------------------------------------------------------------------
module crcfc_fifo #(
  parameter int DEPTH = crcfc_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  input  wire crcfc_pkg::entry_t push_entry,
  output logic                   full,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output crcfc_pkg::entry_t      pop_entry
);
  import crcfc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             pop;

  assign full      = (count_r == CNT_FULL);
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_entry = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_valid && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push_valid) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### design/crcfc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC16 frame checker back end
// Captures header fields, runs the CRC and registers one result per byte.
// ----------------------------------------------------------------------------
module crcfc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire crcfc_pkg::cfg_t   cfg,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire crcfc_pkg::entry_t pop_entry,
  crcfc_out_if.source            out_ch
);
  import crcfc_pkg::*;

  logic [7:0]         head_r, cmd_r, len_r;
  logic [15:0]        crc_r, last2_r;
  logic [7:0]         head_nxt, cmd_nxt, len_nxt;
  logic [15:0]        crc_nxt, last2_nxt;
  logic [POS_W-1:0]   p;
  logic [COUNT_W-1:0] count;
  logic               pay;
  logic               take;
  status_t            status;

  logic       out_valid_r;
  logic [7:0] out_byte_r, out_cmd_r, out_len_r;
  logic       out_pay_r, out_done_r;
  status_t    out_status_r;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign take      = pop_valid && pop_ready;
  assign p         = pop_entry.pos;
  assign count     = {1'b0, p} + 1'b1;

  always_comb begin
    head_nxt  = (p == POS_HEAD) ? pop_entry.rx_byte : head_r;
    cmd_nxt   = (p == POS_CMD)  ? pop_entry.rx_byte : cmd_r;
    len_nxt   = (p == POS_LEN)  ? pop_entry.rx_byte : len_r;
    pay       = (p >= POS_PAYLOAD) && (p < (POS_PAYLOAD + {3'b000, len_nxt}));
    crc_nxt   = (p >= POS_LEN) ? crc_step(crc_r, last2_r[15:8]) : crc_r;
    last2_nxt = {last2_r[7:0], pop_entry.rx_byte};
    priority if (count > {2'b00, cfg.max_burst}) begin
      status = ST_TOO_LONG;
    end else if (head_nxt != cfg.own_head && head_nxt != cfg.both_head) begin
      status = ST_BAD_HEAD;
    end else if ({3'b000, {1'b0, len_nxt} + FRAME_EXTRA} != count) begin
      status = ST_BAD_LEN;
    end else if (crc_nxt != last2_nxt) begin
      status = ST_BAD_CRC;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      cmd_r       <= '0;
      len_r       <= '0;
      crc_r       <= CRC_INIT;
      last2_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        if (pop_entry.burst_end) begin
          head_r  <= '0;
          cmd_r   <= '0;
          len_r   <= '0;
          crc_r   <= CRC_INIT;
          last2_r <= '0;
        end else begin
          head_r  <= head_nxt;
          cmd_r   <= cmd_nxt;
          len_r   <= len_nxt;
          crc_r   <= crc_nxt;
          last2_r <= last2_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r   <= pop_entry.rx_byte;
      out_pay_r    <= pay;
      out_done_r   <= pop_entry.burst_end;
      out_status_r <= pop_entry.burst_end ? status : ST_OK;
      out_cmd_r    <= cmd_nxt;
      out_len_r    <= len_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.payload_byte  = out_byte_r;
  assign out_ch.payload_valid = out_pay_r;
  assign out_ch.frame_done    = out_done_r;
  assign out_ch.frame_status  = out_status_r;
  assign out_ch.command_code  = out_cmd_r;
  assign out_ch.payload_len   = out_len_r;

endmodule
`default_nettype wire

### design/crc16_frame_checker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CRC16 frame checker
// Checks head, length and CRC16 of received frames and echoes every byte.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while the queue has room and
// returns one result per byte, held first in the queue and then in the
// output register. A front end tags each byte with its position in the
// burst and a back end keeps the header fields and the CRC16 (polynomial
// 0x1021, init 0xFFFF), so a stall on the result side only fills the short
// queue before input transfers stop. Status is valid with frame_done on the
// burst's last byte. Registers may be written only while no transfer is in
// flight; the write port is always ready.
module crc16_frame_checker_top #(
  parameter int QUEUE_DEPTH = crcfc_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  crcfc_in_if.sink   in_ch,
  crcfc_out_if.source out_ch,
  crcfc_cfg_if.sink  cfg_ch
);
  import crcfc_pkg::*;

  cfg_t   cfg_r;
  logic   push_valid;
  entry_t push_entry;
  logic   q_full;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_head  <= '0;
      cfg_r.both_head <= '0;
      cfg_r.max_burst <= MAX_LEN_RESET;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_OWN_HEAD:  cfg_r.own_head  <= cfg_ch.data[7:0];
        REG_BOTH_HEAD: cfg_r.both_head <= cfg_ch.data[7:0];
        REG_MAX_BURST: cfg_r.max_burst <= cfg_ch.data[MAX_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  crcfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  crcfc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  crcfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_ch    (out_ch)
  );

  a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.frame_done |-> out_ch.frame_status == ST_OK)
    else $error("frame status set on a byte that does not end the burst");

  a_ok_frame_ends_in_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_done && out_ch.frame_status == ST_OK
    |-> !out_ch.payload_valid)
    else $error("a good frame ended on a payload byte");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push_valid)
    else $error("byte pushed into a full queue");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid && !pop_valid)
    else $error("result or queue entry present right after reset");

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC16 frame checker testbench
// Sends bursts of received bytes through the checker and compares every echoed
// byte, payload mark, header field and end-of-burst status with a local model
// of the header capture and the CCITT-FALSE CRC16 check. The run steps through
// several register settings and several patterns of idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import crcfc_pkg::*;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_done;
    status_t    frame_status;
    logic [7:0] command_code;
    logic [7:0] payload_len;
  } echo_t;

  logic clk;
  logic rst_n;

  crcfc_in_if  in_ch();
  crcfc_out_if out_ch();
  crcfc_cfg_if cfg_ch();

  crc16_frame_checker_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [7:0]  own_head_cfg;
  logic [7:0]  both_head_cfg;
  logic [9:0]  max_burst_cfg;

  logic [10:0] burst_pos;
  logic [15:0] crc_acc;
  logic [15:0] crc_tail;
  logic [7:0]  head_seen;
  logic [7:0]  cmd_seen;
  logic [7:0]  len_seen;

  echo_t       echo_queue[$];
  logic [7:0]  burst_buf[$];
  int          error_count;
  int          bytes_sent;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_request;
  int          hold_left;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  function automatic void clear_burst();
    burst_pos = '0;
    crc_acc   = CRC_INIT;
    crc_tail  = '0;
    head_seen = '0;
    cmd_seen  = '0;
    len_seen  = '0;
  endfunction

  // The CRC runs two bytes behind, so at burst end the tail holds the
  // received check value and the accumulator covers everything before it.
  function automatic echo_t predict_echo(input logic [7:0] b, input logic is_last);
    echo_t e;
    int    p;
    int    count;
    p = burst_pos;
    if (p == 0) head_seen = b;
    else if (p == 1) cmd_seen = b;
    else if (p == 2) len_seen = b;
    e.payload_byte  = b;
    e.payload_valid = (p >= 3) && (p < 3 + int'(len_seen));
    if (p >= 2) crc_acc = crc16_ccitt_byte(crc_acc, crc_tail[15:8]);
    crc_tail = {crc_tail[7:0], b};
    if (burst_pos != '1) burst_pos = burst_pos + 1'b1;
    e.frame_done   = is_last;
    e.frame_status = ST_OK;
    if (is_last) begin
      count = p + 1;
      if (count > int'(max_burst_cfg)) e.frame_status = ST_TOO_LONG;
      else if (head_seen != own_head_cfg && head_seen != both_head_cfg)
        e.frame_status = ST_BAD_HEAD;
      else if (int'(len_seen) + 5 != count) e.frame_status = ST_BAD_LEN;
      else if (crc_acc != crc_tail) e.frame_status = ST_BAD_CRC;
    end
    e.command_code = cmd_seen;
    e.payload_len  = len_seen;
    if (is_last) clear_burst();
    return e;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    echo_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (echo_queue.size() == 0) begin
        $error("result transfer with no expected result, byte %0h", out_ch.payload_byte);
        error_count++;
      end else begin
        want = echo_queue.pop_front();
        check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
        check_field("payload_valid", want.payload_valid, out_ch.payload_valid);
        check_field("frame_done", want.frame_done, out_ch.frame_done);
        check_field("frame_status", want.frame_status, out_ch.frame_status);
        check_field("command_code", want.command_code, out_ch.command_code);
        check_field("payload_len", want.payload_len, out_ch.payload_len);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.rx_byte   = b;
    in_ch.burst_end = is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    echo_queue.push_back(predict_echo(b, is_last));
    bytes_sent++;
  endtask

  task automatic send_burst();
    foreach (burst_buf[i]) send_byte(burst_buf[i], i == burst_buf.size() - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (echo_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [9:0] data);
    drain();
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_OWN_HEAD:  own_head_cfg  = data[7:0];
      REG_BOTH_HEAD: both_head_cfg = data[7:0];
      REG_MAX_BURST: max_burst_cfg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // A negative fill value asks for random payload bytes.
  function automatic void load_frame(input logic [7:0] head, input logic [7:0] cmd,
                                     input logic [7:0] len, input int fill);
    logic [15:0] crc;
    burst_buf.delete();
    burst_buf.push_back(head);
    burst_buf.push_back(cmd);
    burst_buf.push_back(len);
    for (int i = 0; i < int'(len); i++) begin
      burst_buf.push_back(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
    end
    crc = CRC_INIT;
    foreach (burst_buf[i]) crc = crc16_ccitt_byte(crc, burst_buf[i]);
    burst_buf.push_back(crc[15:8]);
    burst_buf.push_back(crc[7:0]);
  endfunction

  function automatic void load_noise(input logic [7:0] head, input int n);
    burst_buf.delete();
    burst_buf.push_back(head);
    for (int i = 1; i < n; i++) burst_buf.push_back(8'($urandom_range(255)));
  endfunction

  task automatic test_reset_defaults();
    load_frame(8'h00, 8'h12, 8'd3, -1);
    send_burst();
    load_frame(8'h01, 8'h34, 8'd0, -1);
    send_burst();
  endtask

  task automatic test_directed();
    write_reg(REG_OWN_HEAD, 10'h35A);
    write_reg(REG_BOTH_HEAD, 10'h0FF);
    write_reg(REG_MAX_BURST, 10'h3FF);
    load_frame(8'h5A, 8'h00, 8'd0, -1);
    send_burst();
    load_frame(8'hFF, 8'hFF, 8'd1, 8'hFF);
    send_burst();
    load_frame(8'h00, 8'h80, 8'd1, 8'h00);
    send_burst();
    load_frame(8'h5A, 8'h01, 8'd0, -1);
    burst_buf[burst_buf.size() - 1] = burst_buf[burst_buf.size() - 1] ^ 8'h01;
    send_burst();
    load_frame(8'h5A, 8'h02, 8'd2, -1);
    void'(burst_buf.pop_back());
    send_burst();
  endtask

  // Noise bursts of one to four bytes, some ending before the command or length byte arrives.
  task automatic test_short_bursts();
    for (int n = 1; n <= 4; n++) begin
      load_noise(own_head_cfg, n);
      send_burst();
    end
  endtask

  task automatic test_burst_limit();
    write_reg(REG_MAX_BURST, 10'd5);
    load_frame(8'h5A, 8'h10, 8'd0, -1);
    send_burst();
    load_frame(8'h5A, 8'h11, 8'd1, -1);
    send_burst();
    write_reg(REG_MAX_BURST, 10'd6);
    send_burst();
  endtask

  task automatic test_check_order();
    write_reg(REG_MAX_BURST, 10'd5);
    load_frame(8'h33, 8'h20, 8'd0, -1);
    burst_buf.push_back(8'hC3);
    send_burst();
    write_reg(REG_MAX_BURST, 10'h3FF);
    send_burst();
    load_frame(8'hFF, 8'h21, 8'd2, -1);
    burst_buf[2] = 8'd3;
    send_burst();
  endtask

  task automatic test_longest_frame();
    write_reg(REG_MAX_BURST, MAX_LEN_RESET);
    load_frame(8'hFF, 8'h7E, 8'd255, -1);
    send_burst();
  endtask

  task automatic test_backpressure();
    write_reg(REG_MAX_BURST, MAX_LEN_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 80;
    for (int i = 0; i < 3; i++) begin
      load_frame(own_head_cfg, 8'($urandom_range(255)), 8'd8, -1);
      send_burst();
    end
  endtask

  task automatic random_burst();
    int         kind;
    int         pick;
    int         len;
    logic [7:0] head;
    kind = $urandom_range(99);
    pick = $urandom_range(3);
    case (pick)
      0, 1:    head = own_head_cfg;
      2:       head = both_head_cfg;
      default: head = 8'($urandom_range(255));
    endcase
    len = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(12);
    if (kind < 75) begin
      load_frame(head, 8'($urandom_range(255)), 8'(len), -1);
      if (kind >= 62) begin
        pick = $urandom_range(burst_buf.size() - 1);
        burst_buf[pick] = burst_buf[pick] ^ (8'h01 << $urandom_range(7));
      end else if (kind >= 55) begin
        if ($urandom_range(1) == 0) void'(burst_buf.pop_back());
        else burst_buf.push_back(8'($urandom_range(255)));
      end
    end else begin
      load_noise(head, $urandom_range(10, 1));
    end
    send_burst();
  endtask

  task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct,
                           input logic [9:0] max_len);
    int start;
    write_reg(REG_OWN_HEAD, 10'($urandom_range(1023)));
    write_reg(REG_BOTH_HEAD, 10'($urandom_range(1023)));
    write_reg(REG_MAX_BURST, max_len);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_items) random_burst();
  endtask

  task automatic test_random_traffic();
    run_phase(25, 0, 0, MAX_LEN_RESET);
    run_phase(25, 49, 0, 10'h3FF);
    run_phase(25, 0, 49, 10'($urandom_range(40, 5)));
    run_phase(25, 32, 32, MAX_LEN_RESET);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.rx_byte   = '0;
    in_ch.burst_end = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_OWN_HEAD;
    cfg_ch.data     = '0;
    own_head_cfg    = '0;
    both_head_cfg   = '0;
    max_burst_cfg   = MAX_LEN_RESET;
    clear_burst();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_directed();
    test_short_bursts();
    test_burst_limit();
    test_check_order();
    test_longest_frame();
    test_backpressure();
    test_random_traffic();
    drain();
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
